FILE: rtl/snrte_pkg.sv
// ----------------------------------------------------------------------------
// snrte_pkg
// Shared types and constants of the route table engine.
// ----------------------------------------------------------------------------
package snrte_pkg;

    localparam int NodeCount     = 64;
    localparam int AddrW         = $clog2(NodeCount);
    localparam logic [7:0] HopReset  = 8'd17;
    localparam logic [7:0] Broadcast = 8'd255;
    localparam logic [8:0] MaxFrame  = 9'd128;
    localparam logic [8:0] HeaderBytes = 9'd7;

    localparam logic [1:0] ActDrop    = 2'd0;
    localparam logic [1:0] ActDeliver = 2'd1;
    localparam logic [1:0] ActSend    = 2'd2;
    localparam logic [1:0] ActTooBig  = 2'd3;

    localparam logic [1:0] TypeData   = 2'd0;
    localparam logic [1:0] TypeBeacon = 2'd1;
    localparam logic [1:0] TypeSpare2 = 2'd2;
    localparam logic [1:0] TypeSpare3 = 2'd3;

    typedef struct packed {
        logic       func;
        logic [1:0] pkt_kind;
        logic [7:0] seq_no;
        logic [7:0] origin;
        logic [7:0] last_hop;
        logic [7:0] next_hop;
        logic [7:0] target;
        logic [7:0] hop_cnt;
        logic [7:0] payload_size;
        logic [7:0] port;
    } t_in_item;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] out_type;
        logic [7:0] out_seq_no;
        logic [7:0] out_origin;
        logic [7:0] out_last_hop;
        logic [7:0] out_next_hop;
        logic [7:0] out_target;
        logic [7:0] out_hop_cnt;
        logic [7:0] out_size;
        logic [7:0] out_port;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load_item;  // capture input beat
        logic rd_src;     // read entry at own (send) or origin (receive)
        logic rd_dest;    // read next hop of target
        logic decide;     // evaluate and write back
        logic cfg_clr;    // reset old own entry
        logic cfg_set;    // set new own entry
        logic load_cfg;   // capture config beat
    } t_cmd;

    typedef struct packed {
        logic cfg_ok;     // captured address in table
    } t_sts;

endpackage

FILE: rtl/snrte_ctrl.sv
// ----------------------------------------------------------------------------
// snrte_ctrl
// Sequencer: item read, dest read, decide/write; result valid; config clear/set.
// ----------------------------------------------------------------------------
module snrte_ctrl
    import snrte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_RDS, S_RDD, S_DEC, S_CCLR, S_CSET
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    o_cmd.load_cfg = 1'b1;
                    n_state = S_CCLR;
                end else if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_RDS;
                end
            end
            S_RDS: begin
                o_cmd.rd_src = 1'b1;
                n_state = S_RDD;
            end
            S_RDD: begin
                o_cmd.rd_dest = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                // hold while the previous result still waits
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.decide = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CCLR: begin
                o_cmd.cfg_clr = i_sts.cfg_ok;
                n_state = S_CSET;
            end
            S_CSET: begin
                o_cmd.cfg_set = i_sts.cfg_ok;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/snrte_dp.sv
// ----------------------------------------------------------------------------
// snrte_dp
// Route tables, own address and result register.
// ----------------------------------------------------------------------------
module snrte_dp
    import snrte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  logic [7:0] i_cfg_data,
    output t_sts      o_sts,
    output t_out_item o_item
);

    logic [23:0] r_mem [NodeCount];   // {hop, seq, next}
    logic [NodeCount-1:0] r_vld;
    logic [23:0] r_rd;
    logic [7:0]  r_own, r_cfg;
    t_in_item    r_it;
    logic [7:0]  r_hop_s, r_seq_s, r_nxt_s;
    logic        r_src_in;
    logic        r_a_ok;
    logic [AddrW-1:0] r_a_idx;
    t_out_item   r_out;

    logic [7:0] a_addr;
    logic       a_in;
    logic [AddrW-1:0] a_idx;
    logic       w_en;
    logic [AddrW-1:0] w_idx;
    logic [23:0] w_data;
    logic [23:0] rd_eff;
    t_out_item  n_out;

    localparam logic [23:0] EntryReset = {HopReset, 8'd0, Broadcast};

    always_comb begin
        a_addr = i_cmd.rd_src ? (r_it.func ? r_own : r_it.origin) : r_it.target;
        a_in   = (a_addr < 8'(NodeCount));
        a_idx  = a_addr[AddrW-1:0];
    end

    assign rd_eff = (r_a_ok && r_vld[r_a_idx]) ? r_rd : EntryReset;

    assign o_sts.cfg_ok = (r_cfg < 8'(NodeCount));

    // decide
    logic [8:0] inc, tot;
    logic       fresh, shorter, better, upd_seq, upd_path;
    logic [7:0] hop_up, s_new;
    always_comb begin
        inc     = {1'b0, r_it.hop_cnt} + 9'd1;
        hop_up  = inc[8] ? 8'd255 : inc[7:0];
        fresh   = r_it.seq_no >= r_seq_s;
        shorter = inc < {1'b0, r_hop_s};
        better  = fresh || shorter;
        tot     = {1'b0, r_it.payload_size} + HeaderBytes;
        s_new   = r_seq_s + 8'd1;
        n_out   = '0;
        w_en    = 1'b0;
        w_idx   = r_it.origin[AddrW-1:0];
        upd_seq = r_it.seq_no > r_seq_s;
        upd_path = better;
        w_data  = {upd_path ? hop_up : r_hop_s,
                   upd_seq ? r_it.seq_no : r_seq_s,
                   upd_path ? r_it.last_hop : r_nxt_s};
        if (r_it.func) begin
            if (tot > MaxFrame) begin
                n_out.action = ActTooBig;
            end else begin
                w_en  = r_src_in;
                w_idx = r_own[AddrW-1:0];
                w_data = {r_hop_s, s_new, r_nxt_s};
                n_out.action = ActSend;
                n_out.out_type = r_it.pkt_kind;
                n_out.out_seq_no = s_new;
                n_out.out_origin = r_own;
                n_out.out_last_hop = r_own;
                n_out.out_next_hop = (r_it.pkt_kind == TypeBeacon) ? Broadcast : rd_eff[7:0];
                n_out.out_target = (r_it.pkt_kind == TypeBeacon) ? Broadcast : r_it.target;
                n_out.out_size = tot[7:0];
                n_out.out_port = r_it.port;
            end
        end else if (r_it.pkt_kind == TypeBeacon) begin
            if (r_it.origin != r_own) begin
                w_en = r_src_in;
                if (better) begin
                    n_out.action = ActSend;
                    n_out.out_type = r_it.pkt_kind;
                    n_out.out_seq_no = r_it.seq_no;
                    n_out.out_origin = r_it.origin;
                    n_out.out_last_hop = r_own;
                    n_out.out_next_hop = Broadcast;
                    n_out.out_target = r_it.target;
                    n_out.out_hop_cnt = hop_up;
                    n_out.out_port = r_it.port;
                end
            end
        end else if (r_it.pkt_kind == TypeData) begin
            w_en = r_src_in;
            if (r_it.target == r_own) begin
                n_out.action = ActDeliver;
                n_out.out_type = r_it.pkt_kind;
                n_out.out_seq_no = r_it.seq_no;
                n_out.out_origin = r_it.origin;
                n_out.out_last_hop = r_it.last_hop;
                n_out.out_next_hop = r_it.next_hop;
                n_out.out_target = r_it.target;
                n_out.out_hop_cnt = r_it.hop_cnt;
                n_out.out_port = r_it.port;
            end else if ((r_it.next_hop == r_own || r_it.target == Broadcast) && fresh) begin
                n_out.action = ActSend;
                n_out.out_type = r_it.pkt_kind;
                n_out.out_seq_no = r_it.seq_no;
                n_out.out_origin = r_it.origin;
                n_out.out_last_hop = r_own;
                // dest==src after update: table read was before write
                n_out.out_next_hop = (r_it.target == r_it.origin && r_src_in)
                                     ? w_data[7:0] : rd_eff[7:0];
                n_out.out_target = r_it.target;
                n_out.out_hop_cnt = hop_up;
                n_out.out_port = r_it.port;
            end
        end
        if (i_cmd.cfg_clr) begin
            w_en = 1'b1;
            w_idx = r_own[AddrW-1:0];
            w_data = EntryReset;
        end else if (i_cmd.cfg_set) begin
            w_en = 1'b1;
            w_idx = r_cfg[AddrW-1:0];
            w_data = {8'd0, 8'd0, r_cfg};
        end else if (!i_cmd.decide) begin
            w_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_src || i_cmd.rd_dest) r_rd <= r_mem[a_idx];
        if (w_en) r_mem[w_idx] <= w_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_own <= 8'd0;
        end else begin
            if (w_en) r_vld[w_idx] <= 1'b1;
            if (i_cmd.cfg_set) r_own <= r_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) r_it <= i_item;
        if (i_cmd.load_cfg) r_cfg <= i_cfg_data;
        if (i_cmd.rd_src || i_cmd.rd_dest) begin
            r_a_ok  <= a_in;
            r_a_idx <= a_idx;
        end
        if (i_cmd.rd_src) r_src_in <= a_in;
        if (i_cmd.rd_dest) begin
            r_hop_s <= rd_eff[23:16];
            r_seq_s <= rd_eff[15:8];
            r_nxt_s <= rd_eff[7:0];
        end
        if (i_cmd.decide) r_out <= n_out;
    end

    assign o_item = r_out;

endmodule

FILE: rtl/sensor_net_route_table_engine.sv
// ----------------------------------------------------------------------------
// sensor_net_route_table_engine
// Distance-vector routing header engine.
// ----------------------------------------------------------------------------
// One item steps through accept, source/own entry read, destination read,
// decide and write back. The result sits in an output register from the next
// cycle, so the following item is read while it waits; a result still held at
// that item's decide cycle stalls it there. Two reads and one write per item on
// the single-port route table set these steps. A configuration write steps
// through accept, clear old own entry, set new; both need the address in table.
module sensor_net_route_table_engine
    import snrte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    snrte_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_cfg_valid, .o_cfg_ready,
        .i_out_ready, .o_out_valid, .i_sts(w_sts), .o_cmd(w_cmd)
    );

    snrte_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_item(i_in_data), .i_cfg_data,
        .o_sts(w_sts), .o_item(o_out_data)
    );

endmodule

FILE: rtl/snrte_chk.sv
// ----------------------------------------------------------------------------
// snrte_chk
// Port-level checks of the route table engine.
// ----------------------------------------------------------------------------
module snrte_chk
    import snrte_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data,
    input logic      o_cfg_ready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> o_cfg_ready)
        else $error("input ready outside idle");

    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat accepted mid item");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.action == ActDrop || o_out_data.action == ActTooBig)
        |-> o_out_data.out_port == 8'd0)
        else $error("drop carries payload");

endmodule

bind sensor_net_route_table_engine snrte_chk u_chk (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
    .o_out_data, .o_cfg_ready
);
